>>> sv/sitd_pkg.sv
// package for the signed integer to digit-register write block
// holds request and result types, display codes and sizing constants
// used by sitd_bcd and signed_int_to_digit_writes
package sitd_pkg;

    localparam int NUM_DIGITS_DEF = 8;
    localparam int NUMBER_W       = 32;
    localparam int BCD_DIGITS     = 10;
    localparam int BCD_W          = 4 * BCD_DIGITS;
    localparam int CNT_W          = $clog2(NUMBER_W);
    localparam int DISP_W         = 3;
    localparam int REG_W          = 4;
    localparam int CODE_W         = 4;

    localparam logic [CODE_W-1:0] CODE_ZERO  = 4'h0;
    localparam logic [CODE_W-1:0] CODE_MINUS = 4'hA;
    localparam logic [CODE_W-1:0] CODE_BLANK = 4'hF;

    typedef struct packed {
        logic [DISP_W-1:0]          display_id;
        logic signed [NUMBER_W-1:0] number;
        logic                       zero_fill;
    } t_req;

    typedef struct packed {
        logic [DISP_W-1:0] target_display;
        logic [REG_W-1:0]  digit_register;
        logic [CODE_W-1:0] digit_code;
        logic              last_write;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_ONE,
        S_EMIT
    } t_state;

endpackage

>>> sv/sitd_bcd.sv
// iterative binary to bcd converter, one shift and add-3 step per cycle
// depends on sitd_pkg for widths
module sitd_bcd (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic [sitd_pkg::NUMBER_W-1:0]   i_value,
    output logic                            o_done,
    output logic [sitd_pkg::BCD_W-1:0]      o_bcd
);

    logic [sitd_pkg::NUMBER_W-1:0] r_bin;
    logic [sitd_pkg::BCD_W-1:0]    r_bcd;
    logic [sitd_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [sitd_pkg::BCD_W-1:0]    adj;

    always_comb begin
        for (int i = 0; i < sitd_pkg::BCD_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sitd_pkg::CNT_W'(sitd_pkg::NUMBER_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bcd <= {adj[sitd_pkg::BCD_W-2:0], r_bin[sitd_pkg::NUMBER_W-1]};
            r_bin <= {r_bin[sitd_pkg::NUMBER_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

>>> sv/signed_int_to_digit_writes.sv
// top level: signed number to a run of code-B digit-register writes
// sequencer around a single bcd converter; depends on sitd_pkg and sitd_bcd
//
// channel   dir  handshake                 payload
// request   in   start high, busy low      i_req    (t_req)
// result    out  o_strobe, one cycle each  o_result (t_result)
//
// after the accepting edge a request is converted in 32 shift-add-3 steps and the
// digits are picked up into a register; then one write per cycle, up to
// NUM_DIGITS writes (a single write for a zero without leading zeros), and the
// sequencer returns to idle, where the next request is taken
// synchronous active-low reset returns the sequencer to idle
// results cannot be stalled; each write is on the ports for one cycle
module signed_int_to_digit_writes #(
    parameter int NUM_DIGITS = sitd_pkg::NUM_DIGITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  sitd_pkg::t_req    i_req,
    output logic              o_strobe,
    output sitd_pkg::t_result o_result
);

    localparam int DW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [DW-1:0] LAST_POS = DW'(NUM_DIGITS - 1);
    localparam logic [DW-1:0] LAST_NEG = DW'(NUM_DIGITS - 2);

    sitd_pkg::t_state r_state, n_state;

    logic [sitd_pkg::DISP_W-1:0] r_disp;
    logic                        r_lz;
    logic                        r_neg;
    logic                        r_zero;
    logic [DW-1:0]               r_digit;
    logic [sitd_pkg::BCD_W-1:0]  r_digits;

    logic                          accept;
    logic [sitd_pkg::NUMBER_W-1:0] mag;
    logic                          conv_done;
    logic [sitd_pkg::BCD_W-1:0]    conv_bcd;
    logic [sitd_pkg::CODE_W-1:0]   fill;
    logic                          emit_last;

    assign accept = start && (r_state == sitd_pkg::S_IDLE);
    assign mag    = i_req.number[sitd_pkg::NUMBER_W-1]
                    ? (sitd_pkg::NUMBER_W'(0) - sitd_pkg::NUMBER_W'(i_req.number))
                    : sitd_pkg::NUMBER_W'(i_req.number);
    assign fill      = r_lz ? sitd_pkg::CODE_ZERO : sitd_pkg::CODE_BLANK;
    assign emit_last = r_neg ? (r_digit == LAST_NEG) : (r_digit == LAST_POS);

    sitd_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_value (mag),
        .o_done  (conv_done),
        .o_bcd   (conv_bcd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sitd_pkg::S_IDLE: begin
                if (start) n_state = sitd_pkg::S_CONV;
            end
            sitd_pkg::S_CONV: begin
                if (conv_done) begin
                    if (r_neg) begin
                        n_state = sitd_pkg::S_SIGN;
                    end else if (r_zero && !r_lz) begin
                        n_state = sitd_pkg::S_ONE;
                    end else begin
                        n_state = sitd_pkg::S_EMIT;
                    end
                end
            end
            sitd_pkg::S_SIGN: n_state = sitd_pkg::S_EMIT;
            sitd_pkg::S_ONE:  n_state = sitd_pkg::S_IDLE;
            sitd_pkg::S_EMIT: begin
                if (emit_last) n_state = sitd_pkg::S_IDLE;
            end
            default: n_state = sitd_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        busy                    = 1'b1;
        o_strobe                = 1'b0;
        o_result.target_display = r_disp;
        o_result.digit_register = sitd_pkg::REG_W'(r_digit) + 1'b1;
        o_result.digit_code     = (r_digits != '0) ? r_digits[sitd_pkg::CODE_W-1:0] : fill;
        o_result.last_write     = 1'b0;
        case (r_state)
            sitd_pkg::S_IDLE: busy = 1'b0;
            sitd_pkg::S_CONV: busy = 1'b1;
            sitd_pkg::S_SIGN: begin
                o_strobe                = 1'b1;
                o_result.digit_register = sitd_pkg::REG_W'(NUM_DIGITS);
                o_result.digit_code     = sitd_pkg::CODE_MINUS;
            end
            sitd_pkg::S_ONE: begin
                o_strobe                = 1'b1;
                o_result.digit_register = sitd_pkg::REG_W'(1);
                o_result.digit_code     = sitd_pkg::CODE_ZERO;
                o_result.last_write     = 1'b1;
            end
            sitd_pkg::S_EMIT: begin
                o_strobe            = 1'b1;
                o_result.last_write = emit_last;
            end
            default: busy = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sitd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_disp <= i_req.display_id;
            r_lz   <= i_req.zero_fill;
            r_neg  <= i_req.number[sitd_pkg::NUMBER_W-1];
            r_zero <= (i_req.number == '0);
        end
        if (r_state == sitd_pkg::S_CONV) begin
            r_digit  <= '0;
            r_digits <= conv_bcd;
        end else if (r_state == sitd_pkg::S_EMIT) begin
            r_digit  <= r_digit + 1'b1;
            r_digits <= {4'h0, r_digits[sitd_pkg::BCD_W-1:4]};
        end
    end

endmodule
